FILE: design/go_to_goal_velocity_controller_assert.svh
// Assertion macros for the go-to-goal velocity controller.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on clk, ignored while reset is active.
`define GTGVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on clk, including the reset cycles.
`define GTGVC_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTGVC_ASSERT(label, prop, msg)
`define GTGVC_ASSERT_NR(label, prop, msg)
`endif

`endif

FILE: design/gtgvc_pkg.sv
// Shared constants, types and the arctangent table of the go-to-goal controller.
`timescale 1ns / 1ps
`default_nettype none

package gtgvc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 17;
  localparam int PIPE_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  localparam int POS_W   = 16;
  localparam int HD_W    = 15;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 15;
  localparam int ANG_W   = 14;

  localparam int D_W    = POS_W + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int DIST_W = 17;
  localparam int PROD_W = GAIN_W + DIST_W;

  localparam int CORDIC_PRESHIFT = 12;
  localparam int CX_W  = 32;
  localparam int Z_W   = 24;
  localparam int ERR_W = 26;
  localparam int HD_SHIFT = 8;
  localparam int RND_SHIFT = 8;

  localparam logic signed [Z_W-1:0]   ANG_HALF_PI = Z_W'(1647099);
  localparam logic signed [ERR_W-1:0] ANG_PI      = ERR_W'(3294199);
  localparam logic signed [ERR_W-1:0] ANG_TWO_PI  = ERR_W'(6588397);
  localparam logic [ERR_W-1:0]        RND_HALF    = ERR_W'(128);
  localparam logic [ANG_W-1:0]        ANG_MAX     = '1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_X       = 3'd0,
    CFG_TARGET_Y       = 3'd1,
    CFG_SPEED_GAIN     = 3'd2,
    CFG_MAX_SPEED      = 3'd3,
    CFG_ARRIVE_RADIUS  = 3'd4,
    CFG_TURN_THRESHOLD = 3'd5
  } cfg_reg_t;

  localparam logic signed [POS_W-1:0] RST_TARGET_X       = -16'sd614;
  localparam logic signed [POS_W-1:0] RST_TARGET_Y       = -16'sd614;
  localparam logic [GAIN_W-1:0]       RST_SPEED_GAIN     = 16'd19661;
  localparam logic [SPEED_W-1:0]      RST_MAX_SPEED      = 15'd1024;
  localparam logic [SPEED_W-1:0]      RST_ARRIVE_RADIUS  = 15'd102;
  localparam logic [ANG_W-1:0]        RST_TURN_THRESHOLD = 14'd819;

  // atan(2^-i) in Q.20 radians
  function automatic logic signed [Z_W-1:0] atan_q20(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = Z_W'(823550);
      1:  v = Z_W'(486170);
      2:  v = Z_W'(256879);
      3:  v = Z_W'(130396);
      4:  v = Z_W'(65451);
      5:  v = Z_W'(32757);
      6:  v = Z_W'(16383);
      7:  v = Z_W'(8192);
      8:  v = Z_W'(4096);
      9:  v = Z_W'(2048);
      10: v = Z_W'(1024);
      11: v = Z_W'(512);
      12: v = Z_W'(256);
      13: v = Z_W'(128);
      14: v = Z_W'(64);
      15: v = Z_W'(32);
      16: v = Z_W'(16);
      17: v = Z_W'(8);
      18: v = Z_W'(4);
      19: v = Z_W'(2);
      20: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/go_to_goal_velocity_controller.sv
// Go-to-goal velocity controller: pipelined distance, bearing and command select.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pose per request: in_current_x,
//   in_current_y (signed Q5.10) and in_heading (signed Q2.12 rad). Output channel
//   (out_valid / out_stall) returns one command per pose, in order: out_linear_speed
//   (Q5.10) and out_angular_speed (Q2.12 rad); the unused one is zero.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high, only
//   while the pipeline is empty. Unknown indexes are ignored.
//   Pipeline: stages 1 and 2, the sum register, the iteration stages, post 1 and 2,
//   then the output register. The iteration length is set by the one-bit-per-stage
//   square root (17 stages) running beside the CORDIC vectoring stages.
//   Throughput: one pose per cycle while the receiver does not stall.
//   Stall: when a result waits in the output register with out_stall high, the whole
//   pipeline holds and in_stall goes high; no request is lost or repeated.
//   Reset (rst_n low, synchronous): all valid bits clear and the configuration
//   registers return to target (-0.6, -0.6), gain 0.3, max speed 1.0,
//   arrive radius 0.1, turn threshold 0.2 rad.
`timescale 1ns / 1ps
`default_nettype none

`include "go_to_goal_velocity_controller_assert.svh"

module go_to_goal_velocity_controller (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [gtgvc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [gtgvc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [gtgvc_pkg::POS_W-1:0]     in_current_x,
  input  wire logic signed [gtgvc_pkg::POS_W-1:0]     in_current_y,
  input  wire logic signed [gtgvc_pkg::HD_W-1:0]      in_heading,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [gtgvc_pkg::SPEED_W-1:0]               out_linear_speed,
  output logic [gtgvc_pkg::ANG_W-1:0]                 out_angular_speed
);

  localparam int NS = gtgvc_pkg::PIPE_STEPS;

  // configuration registers
  logic signed [gtgvc_pkg::POS_W-1:0] target_x_r, target_y_r;
  logic [gtgvc_pkg::GAIN_W-1:0]       speed_gain_r;
  logic [gtgvc_pkg::SPEED_W-1:0]      max_speed_r;
  logic [gtgvc_pkg::SPEED_W-1:0]      arrive_radius_r;
  logic [gtgvc_pkg::ANG_W-1:0]        turn_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r       <= gtgvc_pkg::RST_TARGET_X;
      target_y_r       <= gtgvc_pkg::RST_TARGET_Y;
      speed_gain_r     <= gtgvc_pkg::RST_SPEED_GAIN;
      max_speed_r      <= gtgvc_pkg::RST_MAX_SPEED;
      arrive_radius_r  <= gtgvc_pkg::RST_ARRIVE_RADIUS;
      turn_threshold_r <= gtgvc_pkg::RST_TURN_THRESHOLD;
    end else if (cfg_we) begin
      case (gtgvc_pkg::cfg_reg_t'(cfg_index))
        gtgvc_pkg::CFG_TARGET_X:       target_x_r <= cfg_data[gtgvc_pkg::POS_W-1:0];
        gtgvc_pkg::CFG_TARGET_Y:       target_y_r <= cfg_data[gtgvc_pkg::POS_W-1:0];
        gtgvc_pkg::CFG_SPEED_GAIN:     speed_gain_r <= cfg_data[gtgvc_pkg::GAIN_W-1:0];
        gtgvc_pkg::CFG_MAX_SPEED:      max_speed_r <= cfg_data[gtgvc_pkg::SPEED_W-1:0];
        gtgvc_pkg::CFG_ARRIVE_RADIUS:  arrive_radius_r <= cfg_data[gtgvc_pkg::SPEED_W-1:0];
        gtgvc_pkg::CFG_TURN_THRESHOLD: turn_threshold_r <= cfg_data[gtgvc_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result is held at the output
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: offsets to target ----------------
  logic                                s1_vld_r;
  logic signed [gtgvc_pkg::D_W-1:0]    s1_dx_r, s1_dy_r;
  logic signed [gtgvc_pkg::HD_W-1:0]   s1_hd_r;
  logic signed [gtgvc_pkg::D_W-1:0]    s1_dx_nxt, s1_dy_nxt;

  assign s1_dx_nxt = {target_x_r[gtgvc_pkg::POS_W-1], target_x_r}
                   - {in_current_x[gtgvc_pkg::POS_W-1], in_current_x};
  assign s1_dy_nxt = {target_y_r[gtgvc_pkg::POS_W-1], target_y_r}
                   - {in_current_y[gtgvc_pkg::POS_W-1], in_current_y};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= s1_dx_nxt;
      s1_dy_r <= s1_dy_nxt;
      s1_hd_r <= in_heading;
    end
  end

  // ---------------- stage 2: squares and quadrant pre-rotation ----------------
  logic                                s2_vld_r;
  logic [gtgvc_pkg::SQ_W-1:0]          s2_sqx_r, s2_sqy_r;
  logic signed [gtgvc_pkg::CX_W-1:0]   s2_x_r, s2_y_r;
  logic signed [gtgvc_pkg::Z_W-1:0]    s2_z_r;
  logic                                s2_zero_r;
  logic signed [gtgvc_pkg::HD_W-1:0]   s2_hd_r;

  logic signed [gtgvc_pkg::SQ_W-1:0]   sqx_full, sqy_full;
  logic signed [gtgvc_pkg::CX_W-1:0]   dxw, dyw;
  logic signed [gtgvc_pkg::CX_W-1:0]   s2_x_nxt, s2_y_nxt;
  logic signed [gtgvc_pkg::Z_W-1:0]    s2_z_nxt;

  assign sqx_full = s1_dx_r * s1_dx_r;
  assign sqy_full = s1_dy_r * s1_dy_r;

  assign dxw = {{(gtgvc_pkg::CX_W - gtgvc_pkg::D_W - gtgvc_pkg::CORDIC_PRESHIFT)
                 {s1_dx_r[gtgvc_pkg::D_W-1]}}, s1_dx_r, {gtgvc_pkg::CORDIC_PRESHIFT{1'b0}}};
  assign dyw = {{(gtgvc_pkg::CX_W - gtgvc_pkg::D_W - gtgvc_pkg::CORDIC_PRESHIFT)
                 {s1_dy_r[gtgvc_pkg::D_W-1]}}, s1_dy_r, {gtgvc_pkg::CORDIC_PRESHIFT{1'b0}}};

  // fold the left half-plane into the right one by a quarter turn
  always_comb begin
    s2_x_nxt = dxw;
    s2_y_nxt = dyw;
    s2_z_nxt = '0;
    if (s1_dx_r < 0) begin
      if (s1_dy_r >= 0) begin
        s2_x_nxt = dyw;
        s2_y_nxt = -dxw;
        s2_z_nxt = gtgvc_pkg::ANG_HALF_PI;
      end else begin
        s2_x_nxt = -dyw;
        s2_y_nxt = dxw;
        s2_z_nxt = -gtgvc_pkg::ANG_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sqx_r  <= $unsigned(sqx_full);
      s2_sqy_r  <= $unsigned(sqy_full);
      s2_x_r    <= s2_x_nxt;
      s2_y_r    <= s2_y_nxt;
      s2_z_r    <= s2_z_nxt;
      s2_zero_r <= (s1_dx_r == '0) && (s1_dy_r == '0);
      s2_hd_r   <= s1_hd_r;
    end
  end

  // ---------------- iteration stages: square root and CORDIC ----------------
  // index 0 is the register after the sum stage, index k+1 the one after step k
  logic [NS:0]                         step_vld_r;
  logic [gtgvc_pkg::SQ_W-1:0]          rem_r   [NS+1];
  logic [gtgvc_pkg::SQ_W-1:0]          root_r  [NS+1];
  logic signed [gtgvc_pkg::CX_W-1:0]   cx_r    [NS+1];
  logic signed [gtgvc_pkg::CX_W-1:0]   cy_r    [NS+1];
  logic signed [gtgvc_pkg::Z_W-1:0]    cz_r    [NS+1];
  logic [NS:0]                         zero_r;
  logic signed [gtgvc_pkg::HD_W-1:0]   hd_r    [NS+1];

  logic [gtgvc_pkg::SQ_W-1:0]          rem_nxt  [NS];
  logic [gtgvc_pkg::SQ_W-1:0]          root_nxt [NS];
  logic signed [gtgvc_pkg::CX_W-1:0]   cx_nxt   [NS];
  logic signed [gtgvc_pkg::CX_W-1:0]   cy_nxt   [NS];
  logic signed [gtgvc_pkg::Z_W-1:0]    cz_nxt   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    if (k < gtgvc_pkg::SQRT_STEPS) begin : g_sqrt
      localparam logic [gtgvc_pkg::SQ_W-1:0] SqBit =
        gtgvc_pkg::SQ_W'(1) << (2 * (gtgvc_pkg::SQRT_STEPS - 1 - k));
      logic [gtgvc_pkg::SQ_W-1:0] trial;
      logic                       take;
      assign trial       = root_r[k] + SqBit;
      assign take        = rem_r[k] >= trial;
      assign rem_nxt[k]  = take ? rem_r[k] - trial : rem_r[k];
      assign root_nxt[k] = take ? (root_r[k] >> 1) + SqBit : root_r[k] >> 1;
    end else begin : g_sqrt_hold
      assign rem_nxt[k]  = rem_r[k];
      assign root_nxt[k] = root_r[k];
    end

    if (k < gtgvc_pkg::CORDIC_STEPS) begin : g_cordic
      localparam logic signed [gtgvc_pkg::Z_W-1:0] Atan = gtgvc_pkg::atan_q20(k);
      logic signed [gtgvc_pkg::CX_W-1:0] xs, ys;
      logic                              pos;
      assign xs        = cx_r[k] >>> k;
      assign ys        = cy_r[k] >>> k;
      assign pos       = cy_r[k] > 0;
      assign cx_nxt[k] = pos ? cx_r[k] + ys : cx_r[k] - ys;
      assign cy_nxt[k] = pos ? cy_r[k] - xs : cy_r[k] + xs;
      assign cz_nxt[k] = pos ? cz_r[k] + Atan : cz_r[k] - Atan;
    end else begin : g_cordic_hold
      assign cx_nxt[k] = cx_r[k];
      assign cy_nxt[k] = cy_r[k];
      assign cz_nxt[k] = cz_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= s2_sqx_r + s2_sqy_r;
      root_r[0] <= '0;
      cx_r[0]   <= s2_x_r;
      cy_r[0]   <= s2_y_r;
      cz_r[0]   <= s2_z_r;
      zero_r[0] <= s2_zero_r;
      hd_r[0]   <= s2_hd_r;
      for (int k = 0; k < NS; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        root_r[k+1] <= root_nxt[k];
        cx_r[k+1]   <= cx_nxt[k];
        cy_r[k+1]   <= cy_nxt[k];
        cz_r[k+1]   <= cz_nxt[k];
        zero_r[k+1] <= zero_r[k];
        hd_r[k+1]   <= hd_r[k];
      end
    end
  end

  // ---------------- post 1: heading error and gain product ----------------
  logic                                 p1_vld_r;
  logic signed [gtgvc_pkg::ERR_W-1:0]   p1_err_r;
  logic [gtgvc_pkg::DIST_W-1:0]         p1_dist_r;
  logic [gtgvc_pkg::PROD_W-1:0]         p1_prod_r;

  logic [gtgvc_pkg::DIST_W-1:0]         dist_val;
  logic signed [gtgvc_pkg::ERR_W-1:0]   bear_ext, hd_ext;

  assign dist_val = root_r[NS][gtgvc_pkg::DIST_W-1:0];
  // robot on the target: take the bearing as zero
  assign bear_ext = zero_r[NS] ? '0
                  : {{(gtgvc_pkg::ERR_W - gtgvc_pkg::Z_W){cz_r[NS][gtgvc_pkg::Z_W-1]}}, cz_r[NS]};
  assign hd_ext = {{(gtgvc_pkg::ERR_W - gtgvc_pkg::HD_W - gtgvc_pkg::HD_SHIFT)
                    {hd_r[NS][gtgvc_pkg::HD_W-1]}}, hd_r[NS], {gtgvc_pkg::HD_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_err_r  <= bear_ext - hd_ext;
      p1_dist_r <= dist_val;
      p1_prod_r <= speed_gain_r * dist_val;
    end
  end

  // ---------------- post 2: wrap, magnitude, speed cap ----------------
  logic                                 p2_vld_r;
  logic [gtgvc_pkg::ERR_W-1:0]          p2_abs_r;
  logic [gtgvc_pkg::SPEED_W-1:0]        p2_lin_r;
  logic                                 p2_far_r;

  logic signed [gtgvc_pkg::ERR_W-1:0]   err_wrap;
  logic [gtgvc_pkg::DIST_W-1:0]         lin_raw;

  always_comb begin
    err_wrap = p1_err_r;
    if (p1_err_r > gtgvc_pkg::ANG_PI) begin
      err_wrap = p1_err_r - gtgvc_pkg::ANG_TWO_PI;
    end else if (p1_err_r <= -gtgvc_pkg::ANG_PI) begin
      err_wrap = p1_err_r + gtgvc_pkg::ANG_TWO_PI;
    end
  end

  assign lin_raw = p1_prod_r[gtgvc_pkg::PROD_W-1:gtgvc_pkg::GAIN_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_abs_r <= (err_wrap < 0) ? $unsigned(-err_wrap) : $unsigned(err_wrap);
      p2_lin_r <= (lin_raw > {2'b00, max_speed_r}) ? max_speed_r
                                                   : lin_raw[gtgvc_pkg::SPEED_W-1:0];
      p2_far_r <= p1_dist_r > {2'b00, arrive_radius_r};
    end
  end

  // ---------------- output register: round and select command ----------------
  logic [gtgvc_pkg::SPEED_W-1:0]        out_linear_speed_r;
  logic [gtgvc_pkg::ANG_W-1:0]          out_angular_speed_r;

  logic [gtgvc_pkg::ERR_W-1:0]          rnd_sum, rnd_q;
  logic [gtgvc_pkg::ANG_W-1:0]          aerr;
  logic                                 turn;

  assign rnd_sum = p2_abs_r + gtgvc_pkg::RND_HALF;
  assign rnd_q   = rnd_sum >> gtgvc_pkg::RND_SHIFT;
  assign aerr    = (rnd_q > {{(gtgvc_pkg::ERR_W - gtgvc_pkg::ANG_W){1'b0}}, gtgvc_pkg::ANG_MAX})
                 ? gtgvc_pkg::ANG_MAX : rnd_q[gtgvc_pkg::ANG_W-1:0];
  assign turn    = aerr > turn_threshold_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_linear_speed_r  <= (p2_far_r && !turn) ? p2_lin_r : '0;
      out_angular_speed_r <= (p2_far_r && turn) ? aerr : '0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      step_vld_r  <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      step_vld_r  <= {step_vld_r[NS-1:0], s2_vld_r};
      p1_vld_r    <= step_vld_r[NS];
      p2_vld_r    <= p1_vld_r;
      out_valid_r <= p2_vld_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_linear_speed  = out_linear_speed_r;
  assign out_angular_speed = out_angular_speed_r;

  `GTGVC_ASSERT(a_one_command, out_valid |-> (out_linear_speed == '0 || out_angular_speed == '0), "both commands nonzero")
  `GTGVC_ASSERT(a_speed_capped, out_valid |-> (out_linear_speed <= max_speed_r), "linear speed above cap")
  `GTGVC_ASSERT(a_turn_above_thr, (out_valid && out_angular_speed != '0) |-> (out_angular_speed > turn_threshold_r), "turn below threshold")
  `GTGVC_ASSERT(a_accept_enters, (in_valid && !in_stall) |=> s1_vld_r, "accepted request not in stage 1")
  `GTGVC_ASSERT_NR(a_reset_clears, !rst_n |=> !out_valid, "output valid after reset")

endmodule

`default_nettype wire
